// ===== design/cvs_pkg.sv =====
// Shared constants, codes and types of the cosine vector search block.
package cvs_pkg;

   localparam int ENTRIES = 256;
   localparam int DIM     = 128;

   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ELEM_AW = (DIM > 1) ? $clog2(DIM) : 1;

   // Accumulator widths: a product of two Q1.15 values needs 32 bits signed,
   // a square 31 bits unsigned, and DIM of them add ELEM_AW bits.
   localparam int DOT_W = 32 + ELEM_AW;
   localparam int NRM_W = 31 + ELEM_AW;

   localparam logic [63:0] SIM_EPS = 64'd43980465;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [63:0]        key;
      logic [ELEM_AW-1:0] elem;
      logic signed [15:0] value;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ===== design/cvs_front.sv =====
// Front end: accepts requests, drops out-of-range elements and queues commands.
module cvs_front import cvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_name_key,
   input  logic [6:0]         req_element_index,
   input  logic signed [15:0] req_feature_value,
   output head_type           head,
   input  logic               pop
);

   cmd_type              q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 keep;
   logic                 push;
   logic                 do_pop;
   cmd_type              in_cmd;

   assign busy = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));

   always_comb begin
      keep = 1'b1;
      if (req_operation == OP_INSERT || req_operation == OP_QUERY) begin
         keep = (int'(req_element_index) < DIM);
      end
      in_cmd.op    = req_operation;
      in_cmd.key   = req_name_key;
      in_cmd.elem  = req_element_index[ELEM_AW-1:0];
      in_cmd.value = req_feature_value;
      in_cmd.last  = (int'(req_element_index) == DIM - 1);
   end

   assign push   = start && !busy && keep;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

// ===== design/cvs_sim.sv =====
// Similarity unit: square roots, denominator and a bit-serial divide to Q1.15.
module cvs_sim import cvs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DOT_W-1:0] dot,
   input  logic [NRM_W-1:0]        n1,
   input  logic [NRM_W-1:0]        n2,
   output logic                    done,
   output logic signed [15:0]      value
);

   localparam int V_W    = NRM_W + 12;
   localparam int R_W    = (V_W + 1) / 2;
   localparam int DEN_W  = 2 * R_W + 1;
   localparam int NUM_W  = DOT_W + 27;
   localparam int DV_W   = ((NUM_W > DEN_W + 16) ? NUM_W : DEN_W + 16) + 1;
   localparam int STEP_W = 4;

   typedef enum logic [2:0] {
      S_IDLE, S_ROOT, S_MUL, S_EPS, S_OVF, S_DIV, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [V_W-1:0]     v1_ff, v1_in, v2_ff, v2_in;
   logic [V_W-1:0]     r1_ff, r1_in, r2_ff, r2_in;
   logic [V_W-1:0]     bit_ff, bit_in;
   logic [V_W-1:0]     t1, t2;
   logic               neg_ff, neg_in;
   logic [DOT_W-1:0]   mag_ff, mag_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DV_W-1:0]    rem_ff, rem_in, dsh_ff, dsh_in, num;
   logic [15:0]        q_ff, q_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               done_ff, done_in;
   logic signed [15:0] value_ff, value_in;
   logic [2*R_W-1:0]   prod;

   assign prod = r1_ff[R_W-1:0] * r2_ff[R_W-1:0];
   assign num  = DV_W'(mag_ff) << 27;

   always_comb begin
      state_in = state_ff;
      v1_in    = v1_ff;
      v2_in    = v2_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      bit_in   = bit_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      t1       = r1_ff + bit_ff;
      t2       = r2_ff + bit_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               v1_in    = {n1, 12'd0};
               v2_in    = {n2, 12'd0};
               r1_in    = '0;
               r2_in    = '0;
               bit_in   = V_W'(1) << (2 * (R_W - 1));
               neg_in   = dot[DOT_W-1];
               mag_in   = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            // One result bit of each floor square root per cycle.
            if (v1_ff >= t1) begin
               v1_in = v1_ff - t1;
               r1_in = (r1_ff >> 1) + bit_ff;
            end else begin
               r1_in = r1_ff >> 1;
            end
            if (v2_ff >= t2) begin
               v2_in = v2_ff - t2;
               r2_in = (r2_ff >> 1) + bit_ff;
            end else begin
               r2_in = r2_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == V_W'(1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            den_in   = DEN_W'(prod);
            state_in = S_EPS;
         end
         S_EPS: begin
            den_in   = den_ff + SIM_EPS[DEN_W-1:0];
            state_in = S_OVF;
         end
         S_OVF: begin
            // A quotient of 2^16 or more clamps whatever its low bits are.
            if (num >= (DV_W'(den_ff) << 16)) begin
               q_in     = 16'hFFFF;
               state_in = S_OUT;
            end else begin
               rem_in   = num;
               dsh_in   = DV_W'(den_ff) << 15;
               q_in     = '0;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               q_in   = {q_ff[14:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(15)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (neg_ff) begin
               value_in = (q_ff >= 16'd32768) ? 16'sh8000 : 16'(~q_ff + 16'd1);
            end else begin
               value_in = (q_ff >= 16'd32768) ? 16'sh7FFF : q_ff;
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      v1_ff    <= v1_in;
      v2_ff    <= v2_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      bit_ff   <= bit_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

// ===== design/cvs_back.sv =====
// Back end: table storage, key scans, vector copy and the similarity search.
module cvs_back import cvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  head_type           head,
   output logic               pop,
   output logic               rsp_valid,
   output logic [1:0]         rsp_reply_kind,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_assigned_index,
   output logic [63:0]        rsp_best_name_key,
   output logic signed [15:0] rsp_similarity
);

   localparam int FS_AW = SLOT_W + ELEM_AW;

   typedef enum logic [2:0] {
      S_IDLE, S_KSCAN, S_COPY, S_QSLOT, S_QACC, S_QSIM
   } state_type;

   logic signed [15:0] ivec_mem [DIM];
   logic [63:0]        key_mem  [ENTRIES];
   logic signed [15:0] fs_mem   [ENTRIES * DIM];

   logic signed [15:0] ivec_q, fs_q;
   logic [63:0]        keys_q;
   logic               ivec_we, keys_we, fs_we;
   logic [SLOT_W-1:0]  keys_ra;
   logic [FS_AW-1:0]   fs_ra, fs_wa;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [63:0]        key_ff, key_in;
   logic [SLOT_W:0]    cnt_ff, cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic               present_ff, present_in, found_ff, found_in;
   logic [SLOT_W-1:0]  free_ff, free_in;
   logic [ELEM_AW:0]   ecnt_ff, ecnt_in;
   logic               erd_vld_ff, erd_vld_in, erd_last_ff, erd_last_in;
   logic [ELEM_AW-1:0] erd_elem_ff, erd_elem_in;
   logic               p2_vld_ff, p2_vld_in, p2_last_ff, p2_last_in;
   logic signed [31:0] p_ab_ff, p_ab_in;
   logic [30:0]        p_aa_ff, p_aa_in, p_bb_ff, p_bb_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   logic [NRM_W-1:0]   n1_ff, n1_in, n2_ff, n2_in;
   logic [SLOT_W:0]    sl_ff, sl_in;
   logic               any_ff, any_in;
   logic [63:0]        best_key_ff, best_key_in;
   logic signed [15:0] best_sim_ff, best_sim_in;
   logic [31:0]        next_index_ff, next_index_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               sim_start_ff, sim_start_in;
   logic               sim_done;
   logic signed [15:0] sim_value;
   logic               ins_resp;
   logic               rv, match;
   logic signed [31:0] ab_c, aa_c, bb_c;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in, rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_index_ff, rsp_index_in;
   logic [63:0]        rsp_key_ff, rsp_key_in;
   logic signed [15:0] rsp_sim_ff, rsp_sim_in;

   cvs_sim u_sim (
      .clock (clock),
      .reset (reset),
      .start (sim_start_ff),
      .dot   (dot_ff),
      .n1    (n1_ff),
      .n2    (n2_ff),
      .done  (sim_done),
      .value (sim_value)
   );

   assign keys_ra = (state_ff == S_KSCAN) ? cnt_ff[SLOT_W-1:0] : sl_ff[SLOT_W-1:0];
   assign fs_ra   = {sl_ff[SLOT_W-1:0], ecnt_ff[ELEM_AW-1:0]};
   assign fs_wa   = {free_ff, erd_elem_ff};

   always_ff @(posedge clock) begin
      if (ivec_we) begin
         ivec_mem[head.cmd.elem] <= head.cmd.value;
      end
      ivec_q <= ivec_mem[ecnt_ff[ELEM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (keys_we) begin
         key_mem[free_ff] <= key_ff;
      end
      keys_q <= key_mem[keys_ra];
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_wa] <= ivec_q;
      end
      fs_q <= fs_mem[fs_ra];
   end

   assign ab_c = ivec_q * fs_q;
   assign aa_c = ivec_q * ivec_q;
   assign bb_c = fs_q * fs_q;

   assign rv    = valid_ff[rd_slot_ff];
   assign match = rv && (keys_q == key_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = rd_slot_ff;
      present_in    = present_ff;
      found_in      = found_ff;
      free_in       = free_ff;
      ecnt_in       = ecnt_ff;
      erd_vld_in    = 1'b0;
      erd_last_in   = 1'b0;
      erd_elem_in   = erd_elem_ff;
      p2_vld_in     = 1'b0;
      p2_last_in    = 1'b0;
      p_ab_in       = ab_c;
      p_aa_in       = aa_c[30:0];
      p_bb_in       = bb_c[30:0];
      dot_in        = dot_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      sl_in         = sl_ff;
      any_in        = any_ff;
      best_key_in   = best_key_ff;
      best_sim_in   = best_sim_ff;
      next_index_in = next_index_ff;
      valid_in      = valid_ff;
      sim_start_in  = 1'b0;
      pop           = 1'b0;
      ivec_we       = 1'b0;
      keys_we       = 1'b0;
      fs_we         = 1'b0;
      ins_resp      = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = op_ff;
      rsp_status_in = ST_OK;
      rsp_index_in  = '0;
      rsp_key_in    = '0;
      rsp_sim_in    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               op_in  = head.cmd.op;
               key_in = head.cmd.key;
               unique case (head.cmd.op) inside
                  OP_INSERT, OP_QUERY: begin
                     ivec_we = 1'b1;
                     if (head.cmd.last) begin
                        if (head.cmd.op == OP_INSERT) begin
                           cnt_in     = '0;
                           present_in = 1'b0;
                           found_in   = 1'b0;
                           state_in   = S_KSCAN;
                        end else begin
                           sl_in       = '0;
                           any_in      = 1'b0;
                           best_key_in = '0;
                           best_sim_in = '0;
                           state_in    = S_QSLOT;
                        end
                     end
                  end
                  OP_DELETE: begin
                     cnt_in   = '0;
                     state_in = S_KSCAN;
                  end
                  OP_CLEAR: begin
                     valid_in      = '0;
                     next_index_in = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = OP_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         S_KSCAN: begin
            if (cnt_ff != (SLOT_W+1)'(ENTRIES)) begin
               rd_vld_in  = 1'b1;
               rd_slot_in = cnt_ff[SLOT_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (op_ff == OP_INSERT) begin
                  present_in = present_ff || match;
                  if (!rv && !found_ff) begin
                     found_in = 1'b1;
                     free_in  = rd_slot_ff;
                  end
               end else if (match) begin
                  valid_in[rd_slot_ff] = 1'b0;
               end
               if (rd_slot_ff == SLOT_W'(ENTRIES - 1)) begin
                  state_in = S_IDLE;
                  if (op_ff == OP_INSERT) begin
                     if (present_in) begin
                        ins_resp = 1'b1;
                     end else if (found_in) begin
                        ecnt_in  = '0;
                        state_in = S_COPY;
                     end else begin
                        ins_resp      = 1'b1;
                        rsp_status_in = ST_FULL;
                     end
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         S_COPY: begin
            if (ecnt_ff != (ELEM_AW+1)'(DIM)) begin
               erd_vld_in  = 1'b1;
               erd_elem_in = ecnt_ff[ELEM_AW-1:0];
               erd_last_in = (ecnt_ff == (ELEM_AW+1)'(DIM - 1));
               ecnt_in     = ecnt_ff + 1'b1;
            end
            if (erd_vld_ff) begin
               fs_we = 1'b1;
               if (erd_last_ff) begin
                  keys_we           = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  ins_resp          = 1'b1;
                  state_in          = S_IDLE;
               end
            end
         end
         S_QSLOT: begin
            if (sl_ff == (SLOT_W+1)'(ENTRIES)) begin
               rsp_valid_in = 1'b1;
               if (any_ff) begin
                  rsp_key_in = best_key_ff;
                  rsp_sim_in = best_sim_ff;
               end else begin
                  rsp_status_in = ST_EMPTY;
               end
               state_in = S_IDLE;
            end else if (valid_ff[sl_ff[SLOT_W-1:0]]) begin
               dot_in   = '0;
               n1_in    = '0;
               n2_in    = '0;
               ecnt_in  = '0;
               state_in = S_QACC;
            end else begin
               sl_in = sl_ff + 1'b1;
            end
         end
         S_QACC: begin
            // Memory read, then the three products, then accumulation.
            if (ecnt_ff != (ELEM_AW+1)'(DIM)) begin
               erd_vld_in  = 1'b1;
               erd_elem_in = ecnt_ff[ELEM_AW-1:0];
               erd_last_in = (ecnt_ff == (ELEM_AW+1)'(DIM - 1));
               ecnt_in     = ecnt_ff + 1'b1;
            end
            p2_vld_in  = erd_vld_ff;
            p2_last_in = erd_last_ff;
            if (p2_vld_ff) begin
               dot_in = dot_ff + {{(DOT_W-32){p_ab_ff[31]}}, p_ab_ff};
               n1_in  = n1_ff + NRM_W'(p_aa_ff);
               n2_in  = n2_ff + NRM_W'(p_bb_ff);
               if (p2_last_ff) begin
                  sim_start_in = 1'b1;
                  state_in     = S_QSIM;
               end
            end
         end
         S_QSIM: begin
            if (sim_done) begin
               if (!any_ff || sim_value > best_sim_ff ||
                   (sim_value == best_sim_ff && keys_q < best_key_ff)) begin
                  any_in      = 1'b1;
                  best_sim_in = sim_value;
                  best_key_in = keys_q;
               end
               sl_in    = sl_ff + 1'b1;
               state_in = S_QSLOT;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ins_resp) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = next_index_ff;
         if (next_index_ff != 32'hFFFF_FFFF) begin
            next_index_in = next_index_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_vld_ff     <= 1'b0;
         erd_vld_ff    <= 1'b0;
         p2_vld_ff     <= 1'b0;
         sim_start_ff  <= 1'b0;
         next_index_ff <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         erd_vld_ff    <= erd_vld_in;
         p2_vld_ff     <= p2_vld_in;
         sim_start_ff  <= sim_start_in;
         next_index_ff <= next_index_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      cnt_ff        <= cnt_in;
      rd_slot_ff    <= rd_slot_in;
      present_ff    <= present_in;
      found_ff      <= found_in;
      free_ff       <= free_in;
      ecnt_ff       <= ecnt_in;
      erd_last_ff   <= erd_last_in;
      erd_elem_ff   <= erd_elem_in;
      p2_last_ff    <= p2_last_in;
      p_ab_ff       <= p_ab_in;
      p_aa_ff       <= p_aa_in;
      p_bb_ff       <= p_bb_in;
      dot_ff        <= dot_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      sl_ff         <= sl_in;
      any_ff        <= any_in;
      best_key_ff   <= best_key_in;
      best_sim_ff   <= best_sim_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_sim_ff    <= rsp_sim_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_kind     = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_assigned_index = rsp_index_ff;
   assign rsp_best_name_key  = rsp_key_ff;
   assign rsp_similarity     = rsp_sim_ff;

endmodule

// ===== design/cosine_top1_vector_search.sv =====
// Top level of the cosine similarity nearest-neighbor search block.
// Requests transfer when start is high and busy is low; each element of a
// vector goes into a four-deep command queue, so busy rises only when that
// queue is full. Results appear on the rsp_ ports for exactly one cycle with
// rsp_valid high and cannot be held off. The back end runs one command at a
// time: an element write and a clear are done in its idle state, a delete
// takes one pass over the key memory, an insert that pass plus a copy of
// the vector. A query walks every slot; each valid entry goes through a
// multiply-accumulate over the feature memory read port and then the
// arithmetic unit (25 square root steps, the denominator, and a 16-step
// divide that an overflowing quotient skips).
module cosine_top1_vector_search import cvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_name_key,
   input  logic [6:0]         req_element_index,
   input  logic signed [15:0] req_feature_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_reply_kind,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_assigned_index,
   output logic [63:0]        rsp_best_name_key,
   output logic signed [15:0] rsp_similarity
);

   head_type head;
   logic     pop;

   cvs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_name_key      (req_name_key),
      .req_element_index (req_element_index),
      .req_feature_value (req_feature_value),
      .head              (head),
      .pop               (pop)
   );

   cvs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_reply_kind     (rsp_reply_kind),
      .rsp_status         (rsp_status),
      .rsp_assigned_index (rsp_assigned_index),
      .rsp_best_name_key  (rsp_best_name_key),
      .rsp_similarity     (rsp_similarity)
   );

   a_nonquery_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind != OP_QUERY |->
         rsp_best_name_key == 64'd0 && rsp_similarity == 16'sd0)
      else $error("non-query result carries a key or similarity");

   a_full_on_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_reply_kind == OP_INSERT)
      else $error("table full status on a non-insert result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_reply_kind == OP_QUERY && rsp_best_name_key == 64'd0 &&
         rsp_similarity == 16'sd0)
      else $error("empty table result is not a clean query reply");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("back end took a command from an empty queue");

endmodule

// ===== bench/cvs_checker.sv =====
// Checker for the cosine vector search block: predicts each reply and compares it.
module cvs_checker import cvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_name_key,
   input  logic [6:0]         req_element_index,
   input  logic signed [15:0] req_feature_value,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_reply_kind,
   input  logic [1:0]         rsp_status,
   input  logic [31:0]        rsp_assigned_index,
   input  logic [63:0]        rsp_best_name_key,
   input  logic signed [15:0] rsp_similarity,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] index;
      logic [63:0] key;
      logic [15:0] sim;
   } reply_type;

   reply_type replies_due[$];

   logic signed [15:0] table_vec [ENTRIES][DIM];
   logic [63:0]        table_key [ENTRIES];
   bit                 table_used [ENTRIES];
   logic [31:0]        run_index;
   logic signed [15:0] pending_vec [DIM];

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Cosine of the pending vector against one stored slot, Q1.15 and clamped.
   function automatic int cosine_of_slot(int slot);
      longint dot, a, b;
      longint unsigned n1, n2, mag, den;
      logic [127:0] num, q;
      dot = 0;
      n1 = 0;
      n2 = 0;
      for (int i = 0; i < DIM; i++) begin
         a = pending_vec[i];
         b = table_vec[slot][i];
         dot += a * b;
         n1 += a * a;
         n2 += b * b;
      end
      mag = (dot < 0) ? -dot : dot;
      den = floor_root(n1 << 12) * floor_root(n2 << 12) + SIM_EPS;
      num = {64'd0, mag} << 27;
      q = num / {64'd0, den};
      if (dot < 0) return (q > 32768) ? -32768 : -int'(q[31:0]);
      return (q > 32767) ? 32767 : int'(q[31:0]);
   endfunction

   function automatic reply_type predict_reply(logic [1:0] op, logic [63:0] key, int idx,
                                               logic signed [15:0] val, output bit made);
      reply_type r;
      bit present, got_free, any;
      int free_slot, s, best_sim;
      logic [63:0] best_key;
      r = '{kind: op, status: ST_OK, index: 0, key: 0, sim: 0};
      made = 1;
      if (op == OP_INSERT || op == OP_QUERY) begin
         pending_vec[idx] = val;
         if (idx != DIM - 1) begin
            made = 0;
            return r;
         end
         if (op == OP_INSERT) begin
            present = 0;
            got_free = 0;
            free_slot = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (table_used[i]) begin
                  if (table_key[i] == key) present = 1;
               end else if (!got_free) begin
                  got_free = 1;
                  free_slot = i;
               end
            end
            if (!present) begin
               if (got_free) begin
                  table_used[free_slot] = 1;
                  table_key[free_slot] = key;
                  for (int i = 0; i < DIM; i++) table_vec[free_slot][i] = pending_vec[i];
               end else begin
                  r.status = ST_FULL;
               end
            end
            r.index = run_index;
            if (run_index != 32'hFFFF_FFFF) run_index++;
         end else begin
            any = 0;
            best_sim = 0;
            best_key = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!table_used[i]) continue;
               s = cosine_of_slot(i);
               if (!any || s > best_sim || (s == best_sim && table_key[i] < best_key)) begin
                  any = 1;
                  best_sim = s;
                  best_key = table_key[i];
               end
            end
            if (!any) begin
               r.status = ST_EMPTY;
            end else begin
               r.key = best_key;
               r.sim = best_sim[15:0];
            end
         end
      end else if (op == OP_DELETE) begin
         for (int i = 0; i < ENTRIES; i++)
            if (table_used[i] && table_key[i] == key) table_used[i] = 0;
      end else begin
         for (int i = 0; i < ENTRIES; i++) table_used[i] = 0;
         run_index = 0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      bit made;
      if (reset) begin
         replies_due.delete();
         for (int i = 0; i < ENTRIES; i++) table_used[i] = 0;
         for (int i = 0; i < DIM; i++) pending_vec[i] = 0;
         run_index = 0;
         errors = 0;
      end else begin
         // The reply is checked first: it can only belong to an earlier transfer.
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               errors++;
               if (errors <= 10) $display("reply with none expected: kind %0d", rsp_reply_kind);
            end else begin
               want = replies_due.pop_front();
               if (rsp_reply_kind !== want.kind || rsp_status !== want.status ||
                   rsp_assigned_index !== want.index || rsp_best_name_key !== want.key ||
                   rsp_similarity !== want.sim) begin
                  errors++;
                  if (errors <= 10)
                     $display("reply mismatch: expected %0d/%0d/%0d/%h/%0d got %0d/%0d/%0d/%h/%0d",
                              want.kind, want.status, want.index, want.key,
                              $signed(want.sim), rsp_reply_kind, rsp_status,
                              rsp_assigned_index, rsp_best_name_key, rsp_similarity);
               end
            end
         end
         if (start && !busy) begin
            want = predict_reply(req_operation, req_name_key, int'(req_element_index),
                                 req_feature_value, made);
            if (made) replies_due.push_back(want);
         end
      end
      pending = replies_due.size();
   end
endmodule

// ===== bench/cosine_top1_vector_search_tb.sv =====
// Stimulus and verdict for the cosine vector search block.
module cosine_top1_vector_search_tb;
   import cvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic [63:0]        req_name_key;
   logic [6:0]         req_element_index;
   logic signed [15:0] req_feature_value;
   logic               rsp_valid;
   logic [1:0]         rsp_reply_kind;
   logic [1:0]         rsp_status;
   logic [31:0]        rsp_assigned_index;
   logic [63:0]        rsp_best_name_key;
   logic signed [15:0] rsp_similarity;
   int                 errors, pending;
   int                 cycles;
   int                 random_items;

   cosine_top1_vector_search dut (.*);

   cvs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Drive one item and return at the falling edge after its transfer.
   task automatic put(input logic [1:0] op, input logic [63:0] key, input int idx,
                      input logic [15:0] v);
      start <= 1;
      req_operation <= op;
      req_name_key <= key;
      req_element_index <= 7'(idx);
      req_feature_value <= v;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic maybe_pause();
      int len;
      if ($urandom_range(0, 3) == 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
         start <= 0;
         repeat (len) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      return 64'($urandom_range(0, 15));
   endfunction

   // A few components at random positions, then the closing element.
   task automatic send_vector(input logic [1:0] op, input logic [63:0] key);
      int n;
      n = $urandom_range(0, 6);
      repeat (n) begin
         put(op, {$urandom, $urandom}, $urandom_range(0, DIM - 2), pick_value());
         maybe_pause();
         random_items++;
      end
      put(op, key, DIM - 1, pick_value());
      random_items++;
   endtask

   initial begin
      cycles = 0;
      random_items = 0;
      reset = 1;
      start = 0;
      req_operation = OP_INSERT;
      req_name_key = 0;
      req_element_index = 0;
      req_feature_value = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // A complete vector first, so no position is ever read before written;
      // the query meets an empty table.
      for (int i = 0; i < DIM; i++) put(OP_QUERY, 64'd0, i, (i % 2) ? 16'h7FFF : 16'h8000);
      put(OP_INSERT, 64'd0, DIM - 1, 16'h7FFF);
      put(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, DIM - 1, 16'h7FFF);
      put(OP_INSERT, 64'd0, DIM - 1, 16'h0001);
      put(OP_QUERY, 64'd0, DIM - 1, 16'h7FFF);
      put(OP_DELETE, 64'h1234, 0, 16'h0);
      put(OP_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 16'hFFFF);
      put(OP_QUERY, 64'd0, DIM - 1, 16'h8000);
      // Zero vector in the table and in the query.
      for (int i = 0; i < DIM; i++) put(OP_INSERT, 64'd7, i, 16'h0);
      put(OP_QUERY, 64'd0, DIM - 1, 16'h0);
      put(OP_CLEAR, 64'hA5A5_A5A5_A5A5_A5A5, 127, 16'h8000);
      put(OP_QUERY, 64'd0, DIM - 1, 16'h1234);

      // Fill the table, overflow it, then free one slot and reuse it.
      for (int i = 0; i < ENTRIES; i++) begin
         put(OP_INSERT, 64'd1000 + i, DIM - 1, pick_value());
         maybe_pause();
      end
      put(OP_INSERT, 64'd5000, DIM - 1, 16'h4000);
      put(OP_QUERY, 64'd0, DIM - 1, pick_value());
      put(OP_DELETE, 64'd1005, 0, 16'h0);
      put(OP_INSERT, 64'd6000, DIM - 1, 16'h7FFF);
      put(OP_QUERY, 64'd0, DIM - 1, 16'h7FFF);
      put(OP_CLEAR, 64'd0, 0, 16'h0);

      while (random_items < 170) begin
         case ($urandom_range(0, 24))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: send_vector(OP_INSERT, pick_key());
            12, 13, 14, 15, 16: send_vector(OP_QUERY, pick_key());
            17, 18: begin
               put(OP_DELETE, pick_key(), $urandom_range(0, 127), pick_value());
               random_items++;
            end
            19: begin
               put(OP_CLEAR, {$urandom, $urandom}, $urandom_range(0, 127), pick_value());
               random_items++;
            end
            default: begin
               put(2'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom_range(0, 127),
                   pick_value());
               random_items++;
            end
         endcase
         maybe_pause();
      end
      start <= 0;

      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
